// ===== rtl/rbyuv_pkg.sv =====
// ----------------------------------------------------------------------------
// rbyuv_pkg
// Shared types and fixed-point constants for the RGBA 2x2 block to YUV 4:2:0
// converter.
// ----------------------------------------------------------------------------
package rbyuv_pkg;

    // One input item: a 2x2 block of RGBA8888 pixels (R 7:0, G 15:8, B 23:16, A 31:24)
    typedef struct packed {
        logic [31:0] pixel_top_left;
        logic [31:0] pixel_top_right;
        logic [31:0] pixel_bottom_left;
        logic [31:0] pixel_bottom_right;
    } pixel_block_t;

    // One result item
    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
        logic [7:0] alpha_mean;
    } yuv_result_t;

    // Luma weights, 2^16 scale; products fit in 24 bits
    localparam int unsigned LUMA_W = 24;
    localparam logic [LUMA_W-1:0] Y_KR = 24'd19595;
    localparam logic [LUMA_W-1:0] Y_KG = 24'd38470;
    localparam logic [LUMA_W-1:0] Y_KB = 24'd7471;

    // Chroma weights, 2^18 scale, applied to 10-bit block sums
    localparam int unsigned PROD_W = 26;
    localparam logic [PROD_W-1:0] U_KR = 26'd9634;
    localparam logic [PROD_W-1:0] U_KG = 26'd18940;
    localparam logic [PROD_W-1:0] U_KB = 26'd28574;
    localparam logic [PROD_W-1:0] V_KR = 26'd40305;
    localparam logic [PROD_W-1:0] V_KG = 26'd33751;
    localparam logic [PROD_W-1:0] V_KB = 26'd6554;

    // Chroma accumulators are signed; 28 bits covers the full range
    localparam int unsigned ACC_W = 28;
    localparam logic signed [ACC_W-1:0] C_OFFSET = 28'sh2000000;
    localparam logic signed [ACC_W-1:0] V_MAX    = 28'sh3FC0000;
    localparam int unsigned C_SHIFT = 18;

endpackage

// ===== rtl/rbyuv_luma.sv =====
// ----------------------------------------------------------------------------
// rbyuv_luma
// Three-stage luma pipeline for one pixel: weighted products, sum, byte.
// ----------------------------------------------------------------------------
module rbyuv_luma (
    input  logic        clk,
    input  logic [31:0] pixel,
    output logic [7:0]  luma
);

    localparam int unsigned W = rbyuv_pkg::LUMA_W;

    logic [W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic [W-1:0] prod_r_next, prod_g_next, prod_b_next;
    logic [W-1:0] sum_reg, sum_next;
    logic [7:0]   luma_reg, luma_next;

    // Stage 1: one multiply per channel
    always_comb
    begin
        prod_r_next = {16'd0, pixel[7:0]}   * rbyuv_pkg::Y_KR;
        prod_g_next = {16'd0, pixel[15:8]}  * rbyuv_pkg::Y_KG;
        prod_b_next = {16'd0, pixel[23:16]} * rbyuv_pkg::Y_KB;
    end

    // Stage 2: add the products (never exceeds 24 bits)
    assign sum_next = prod_r_reg + prod_g_reg + prod_b_reg;

    // Stage 3: drop the 16 fraction bits
    assign luma_next = sum_reg[W-1:16];

    always_ff @(posedge clk)
    begin
        prod_r_reg <= prod_r_next;
        prod_g_reg <= prod_g_next;
        prod_b_reg <= prod_b_next;
        sum_reg    <= sum_next;
        luma_reg   <= luma_next;
    end

    assign luma = luma_reg;

endmodule

// ===== rtl/rbyuv_chroma.sv =====
// ----------------------------------------------------------------------------
// rbyuv_chroma
// Three-stage block pipeline: channel sums, weighted products, signed
// accumulate with V clamp. Also carries the alpha mean alongside.
// ----------------------------------------------------------------------------
module rbyuv_chroma (
    input  logic                    clk,
    input  rbyuv_pkg::pixel_block_t pixels,
    output logic [7:0]              chroma_u,
    output logic [7:0]              chroma_v,
    output logic [7:0]              alpha_mean
);

    localparam int unsigned PW = rbyuv_pkg::PROD_W;
    localparam int unsigned AW = rbyuv_pkg::ACC_W;
    localparam int unsigned SH = rbyuv_pkg::C_SHIFT;

    logic [9:0] rs_reg, gs_reg, bs_reg, as_reg;
    logic [9:0] rs_next, gs_next, bs_next, as_next;
    logic [9:0] as_d_reg;

    logic [PW-1:0] ur_reg, ug_reg, ub_reg, vr_reg, vg_reg, vb_reg;
    logic [PW-1:0] ur_next, ug_next, ub_next, vr_next, vg_next, vb_next;

    logic signed [AW-1:0] u_acc, v_acc;
    logic [7:0] u_reg, v_reg, a_reg;
    logic [7:0] u_next, v_next;

    // Stage 1: sum each channel over the four pixels
    always_comb
    begin
        rs_next = 10'(pixels.pixel_top_left[7:0])   + 10'(pixels.pixel_top_right[7:0])
                + 10'(pixels.pixel_bottom_left[7:0]) + 10'(pixels.pixel_bottom_right[7:0]);
        gs_next = 10'(pixels.pixel_top_left[15:8])   + 10'(pixels.pixel_top_right[15:8])
                + 10'(pixels.pixel_bottom_left[15:8]) + 10'(pixels.pixel_bottom_right[15:8]);
        bs_next = 10'(pixels.pixel_top_left[23:16])   + 10'(pixels.pixel_top_right[23:16])
                + 10'(pixels.pixel_bottom_left[23:16]) + 10'(pixels.pixel_bottom_right[23:16]);
        as_next = 10'(pixels.pixel_top_left[31:24])   + 10'(pixels.pixel_top_right[31:24])
                + 10'(pixels.pixel_bottom_left[31:24]) + 10'(pixels.pixel_bottom_right[31:24]);
    end

    // Stage 2: weighted products, all unsigned and under 2^26
    always_comb
    begin
        ur_next = {16'd0, rs_reg} * rbyuv_pkg::U_KR;
        ug_next = {16'd0, gs_reg} * rbyuv_pkg::U_KG;
        ub_next = {16'd0, bs_reg} * rbyuv_pkg::U_KB;
        vr_next = {16'd0, rs_reg} * rbyuv_pkg::V_KR;
        vg_next = {16'd0, gs_reg} * rbyuv_pkg::V_KG;
        vb_next = {16'd0, bs_reg} * rbyuv_pkg::V_KB;
    end

    // Stage 3: signed accumulate; U always lands in range, V is clamped
    always_comb
    begin
        u_acc = rbyuv_pkg::C_OFFSET
              - $signed({2'b00, ur_reg}) - $signed({2'b00, ug_reg})
              + $signed({2'b00, ub_reg});
        v_acc = rbyuv_pkg::C_OFFSET
              + $signed({2'b00, vr_reg}) - $signed({2'b00, vg_reg})
              - $signed({2'b00, vb_reg});
        u_next = u_acc[SH+7:SH];
        if (v_acc[AW-1])
        begin
            v_next = 8'd0;
        end
        else if (v_acc > rbyuv_pkg::V_MAX)
        begin
            v_next = 8'd255;
        end
        else
        begin
            v_next = v_acc[SH+7:SH];
        end
    end

    always_ff @(posedge clk)
    begin
        rs_reg   <= rs_next;
        gs_reg   <= gs_next;
        bs_reg   <= bs_next;
        as_reg   <= as_next;
        ur_reg   <= ur_next;
        ug_reg   <= ug_next;
        ub_reg   <= ub_next;
        vr_reg   <= vr_next;
        vg_reg   <= vg_next;
        vb_reg   <= vb_next;
        as_d_reg <= as_reg;
        u_reg    <= u_next;
        v_reg    <= v_next;
        a_reg    <= as_d_reg[9:2];
    end

    assign chroma_u   = u_reg;
    assign chroma_v   = v_reg;
    assign alpha_mean = a_reg;

endmodule

// ===== rtl/rgba_block_to_yuv420_core.sv =====
// ----------------------------------------------------------------------------
// rgba_block_to_yuv420_core
// RGBA8888 2x2 block to YUV 4:2:0 converter (four luma, one U/V, alpha mean).
// ----------------------------------------------------------------------------
// Usage: one item (a 2x2 pixel block) can be started every clock cycle;
// busy is never asserted. Each item's result appears on result with done
// high for exactly one cycle. The start edge loads the first of three
// datapath stages (luma: products, sum, byte; chroma: sums, products,
// accumulate/clamp); the output register loads from the third stage and
// drives done/result. Results come out in start order. The receiver cannot stall
// the block, so it must take done/result in the cycle they are shown.
module rgba_block_to_yuv420_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  rbyuv_pkg::pixel_block_t pixels,
    output logic                    done,
    output rbyuv_pkg::yuv_result_t  result
);

    logic [2:0] valid_reg, valid_next;
    logic       done_reg;
    rbyuv_pkg::yuv_result_t result_reg, result_next;

    logic [7:0] y_tl, y_tr, y_bl, y_br;
    logic [7:0] u_s, v_s, a_s;

    // Nothing ever backs up: an item is taken on every start
    assign busy = 1'b0;

    // Per-pixel luma pipelines
    rbyuv_luma u_luma_tl (.clk(clk), .pixel(pixels.pixel_top_left),     .luma(y_tl));
    rbyuv_luma u_luma_tr (.clk(clk), .pixel(pixels.pixel_top_right),    .luma(y_tr));
    rbyuv_luma u_luma_bl (.clk(clk), .pixel(pixels.pixel_bottom_left),  .luma(y_bl));
    rbyuv_luma u_luma_br (.clk(clk), .pixel(pixels.pixel_bottom_right), .luma(y_br));

    // Block chroma and alpha pipeline
    rbyuv_chroma u_chroma (
        .clk        (clk),
        .pixels     (pixels),
        .chroma_u   (u_s),
        .chroma_v   (v_s),
        .alpha_mean (a_s)
    );

    // Valid bits ride alongside the three datapath stages
    assign valid_next = {valid_reg[1:0], start & ~busy};

    always_comb
    begin
        result_next.luma_top_left     = y_tl;
        result_next.luma_top_right    = y_tr;
        result_next.luma_bottom_left  = y_bl;
        result_next.luma_bottom_right = y_br;
        result_next.chroma_u          = u_s;
        result_next.chroma_v          = v_s;
        result_next.alpha_mean        = a_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= valid_reg[2];
        end
    end

    // Output register, loaded only for a live item
    always_ff @(posedge clk)
    begin
        if (valid_reg[2])
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== bench/tb_rgba_block_to_yuv420_core.sv =====
// ----------------------------------------------------------------------------
// tb_rgba_block_to_yuv420_core
// Self-checking bench for the 2x2 RGBA block to YUV 4:2:0 converter. A
// clocked driver feeds pixel blocks from a queue. A clocked monitor predicts
// each accepted block's luma, chroma and alpha mean in fixed point, then
// compares every returned result with the oldest prediction, field by field.
// Directed blocks cover channel extremes and both V clamps. Random blocks
// follow, in four phases with sender idle rates of 0, 88, 0 and 19 percent.
// ----------------------------------------------------------------------------
module tb_rgba_block_to_yuv420_core;

    // Fixed-point weights: luma in 2^16 scale, chroma in 2^18 scale
    localparam longint LUMA_R = 19595;
    localparam longint LUMA_G = 38470;
    localparam longint LUMA_B = 7471;
    localparam longint CB_R   = 9634;
    localparam longint CB_G   = 18940;
    localparam longint CB_B   = 28574;
    localparam longint CR_R   = 40305;
    localparam longint CR_G   = 33751;
    localparam longint CR_B   = 6554;
    localparam longint CHROMA_BIAS = 64'h2000000;
    localparam longint CR_CEIL     = 64'h3FC0000;
    localparam int     CHROMA_SHIFT = 18;

    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        rbyuv_pkg::pixel_block_t blk;
        int unsigned             idle_pct;
    } queued_block_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    rbyuv_pkg::pixel_block_t pixels;
    logic                    done;
    rbyuv_pkg::yuv_result_t  result;

    queued_block_t           blocks_waiting[$];
    rbyuv_pkg::yuv_result_t  yuv_due[$];
    logic                    block_taken;
    rbyuv_pkg::pixel_block_t taken_blk;
    int                      mismatches = 0;
    int                      cycle_count = 0;

    rgba_block_to_yuv420_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pixels (pixels),
        .done   (done),
        .result (result)
    );

    // Expected conversion of one 2x2 block
    function automatic rbyuv_pkg::yuv_result_t block_to_yuv(rbyuv_pkg::pixel_block_t b);
        logic [31:0] px [4];
        longint      r_sum;
        longint      g_sum;
        longint      b_sum;
        longint      a_sum;
        longint      y_acc;
        longint      cb_acc;
        longint      cr_acc;
        logic [7:0]  luma [4];
        rbyuv_pkg::yuv_result_t res;
        px[0] = b.pixel_top_left;
        px[1] = b.pixel_top_right;
        px[2] = b.pixel_bottom_left;
        px[3] = b.pixel_bottom_right;
        r_sum = 0;
        g_sum = 0;
        b_sum = 0;
        a_sum = 0;
        for (int k = 0; k < 4; k++)
        begin
            y_acc = longint'(px[k][7:0]) * LUMA_R + longint'(px[k][15:8]) * LUMA_G
                  + longint'(px[k][23:16]) * LUMA_B;
            luma[k] = 8'(y_acc >> 16);
            r_sum += longint'(px[k][7:0]);
            g_sum += longint'(px[k][15:8]);
            b_sum += longint'(px[k][23:16]);
            a_sum += longint'(px[k][31:24]);
        end
        cb_acc = CHROMA_BIAS - CB_R * r_sum - CB_G * g_sum + CB_B * b_sum;
        cr_acc = CHROMA_BIAS + CR_R * r_sum - CR_G * g_sum - CR_B * b_sum;
        if (cb_acc < 0)
            cb_acc = 0;
        // V saturates at both ends
        if (cr_acc > CR_CEIL)
            cr_acc = CR_CEIL;
        else if (cr_acc < 0)
            cr_acc = 0;
        res.luma_top_left     = luma[0];
        res.luma_top_right    = luma[1];
        res.luma_bottom_left  = luma[2];
        res.luma_bottom_right = luma[3];
        res.chroma_u          = 8'(cb_acc >> CHROMA_SHIFT);
        res.chroma_v          = 8'(cr_acc >> CHROMA_SHIFT);
        res.alpha_mean        = 8'(a_sum >> 2);
        return res;
    endfunction

    // Channels lean toward 0 and 255 so the clamps get hit
    function automatic logic [31:0] skewed_pixel();
        logic [31:0] p;
        for (int c = 0; c < 4; c++)
        begin
            case ($urandom_range(5))
                0:       p[c*8 +: 8] = 8'h00;
                1:       p[c*8 +: 8] = 8'hFF;
                default: p[c*8 +: 8] = 8'($urandom);
            endcase
        end
        return p;
    endfunction

    task automatic queue_block(logic [31:0] tl, logic [31:0] tr, logic [31:0] bl,
                               logic [31:0] br, int unsigned idle_pct);
        queued_block_t q;
        q.blk.pixel_top_left     = tl;
        q.blk.pixel_top_right    = tr;
        q.blk.pixel_bottom_left  = bl;
        q.blk.pixel_bottom_right = br;
        q.idle_pct               = idle_pct;
        blocks_waiting.push_back(q);
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Driver: presents queued blocks, idles at the item's rate
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            pixels      <= '0;
            block_taken <= 1'b0;
            taken_blk   <= '0;
        end
        else
        begin
            block_taken <= start && !busy;
            taken_blk   <= pixels;
            if (!start || !busy)
            begin
                if (blocks_waiting.size() > 0 &&
                    $urandom_range(99) >= blocks_waiting[0].idle_pct)
                begin
                    pixels <= blocks_waiting[0].blk;
                    start  <= 1'b1;
                    void'(blocks_waiting.pop_front());
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: records predictions for taken blocks, then checks results
    always @(posedge clk)
    begin
        rbyuv_pkg::yuv_result_t want;
        if (rst_n)
        begin
            if (block_taken)
                yuv_due.push_back(block_to_yuv(taken_blk));
            if (done)
            begin
                if (yuv_due.size() == 0)
                begin
                    $error("result with no block outstanding");
                    mismatches++;
                end
                else
                begin
                    want = yuv_due.pop_front();
                    check_field("luma_top_left", want.luma_top_left, result.luma_top_left);
                    check_field("luma_top_right", want.luma_top_right,
                                result.luma_top_right);
                    check_field("luma_bottom_left", want.luma_bottom_left,
                                result.luma_bottom_left);
                    check_field("luma_bottom_right", want.luma_bottom_right,
                                result.luma_bottom_right);
                    check_field("chroma_u", want.chroma_u, result.chroma_u);
                    check_field("chroma_v", want.chroma_v, result.chroma_v);
                    check_field("alpha_mean", want.alpha_mean, result.alpha_mean);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int unsigned phase_idle [4];
        phase_idle[0] = 0;
        phase_idle[1] = 88;
        phase_idle[2] = 0;
        phase_idle[3] = 19;

        rst_n = 1'b0;

        // Directed: extremes, V clamps, alpha truncation
        queue_block(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0);
        queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        // pure red block: V above range
        queue_block(32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF, 0);
        // pure green block: V below range
        queue_block(32'h0000_FF00, 32'h0000_FF00, 32'h0000_FF00, 32'h0000_FF00, 0);
        queue_block(32'h00FF_0000, 32'h00FF_0000, 32'h00FF_0000, 32'h00FF_0000, 0);
        queue_block(32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 0);
        queue_block(32'hFF00_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0);
        queue_block(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0000_0000, 0);
        queue_block(32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000, 32'hFFFF_FFFF, 0);
        queue_block(32'h00FF_FF00, 32'h00FF_FF00, 32'h0000_00FF, 32'h0000_00FF, 0);
        queue_block(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 0);
        queue_block(32'h7F80_0180, 32'h807F_FE7F, 32'h5555_5555, 32'hAAAA_AAAA, 0);
        // mostly red with a little green: V still above range
        queue_block(32'h0000_08FF, 32'h0000_08FF, 32'h0000_08FF, 32'h0000_08FF, 0);
        queue_block(32'h0000_FF10, 32'h0000_FF10, 32'h0000_FF10, 32'h0000_FF10, 0);

        // Random phases
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int n = 0; n < 300; n++)
            begin
                if ($urandom_range(1))
                    queue_block($urandom, $urandom, $urandom, $urandom, phase_idle[ph]);
                else
                    queue_block(skewed_pixel(), skewed_pixel(), skewed_pixel(),
                                skewed_pixel(), phase_idle[ph]);
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Drain
        while (blocks_waiting.size() > 0 || start || block_taken || yuv_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
